/* design/lwac_pkg.sv */
package lwac_pkg;

  localparam int ERR_W   = 18;
  localparam int MAG_W   = 17;
  localparam int RATE_W  = 12;
  localparam int DRIVE_W = 13;
  localparam int CNT_W   = 16;

  typedef enum logic [2:0] {
    ST_IDLE      = 3'd0,
    ST_ALIGNING  = 3'd1,
    ST_VERIFYING = 3'd2,
    ST_SUCCEEDED = 3'd3,
    ST_TIMED_OUT = 3'd4
  } status_t;

  localparam logic CMD_START = 1'b0;
  localparam logic CMD_TICK  = 1'b1;

  localparam logic [1:0] DIR_RIGHT = 2'd0;
  localparam logic [1:0] DIR_LEFT  = 2'd1;
  localparam logic [1:0] DIR_FRONT = 2'd2;
  localparam logic [1:0] DIR_BACK  = 2'd3;

  localparam logic [2:0] REG_TOLERANCE = 3'd0;
  localparam logic [2:0] REG_GAIN      = 3'd1;
  localparam logic [2:0] REG_MIN_RATE  = 3'd2;
  localparam logic [2:0] REG_MAX_RATE  = 3'd3;
  localparam logic [2:0] REG_DEAD_RATE = 3'd4;
  localparam logic [2:0] REG_VERIFY    = 3'd5;
  localparam logic [2:0] REG_TIMEOUT   = 3'd6;

  typedef struct packed {
    logic [15:0]       tolerance_mm;
    logic [15:0]       gain_q8;
    logic [RATE_W-1:0] min_rate;
    logic [RATE_W-1:0] max_rate;
    logic [RATE_W-1:0] dead_rate;
    logic [CNT_W-1:0]  verify_ticks;
    logic [CNT_W-1:0]  timeout_ticks;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    tolerance_mm:  16'd25,
    gain_q8:       16'd512,
    min_rate:      12'd100,
    max_rate:      12'd800,
    dead_rate:     12'd10,
    verify_ticks:  16'd20,
    timeout_ticks: 16'd300
  };

  typedef struct packed {
    logic                      aligned;
    logic signed [DRIVE_W-1:0] drive;
  } drive_t;

endpackage

/* design/lwac_drive.sv */
module lwac_drive (
  input  logic signed [lwac_pkg::ERR_W-1:0] err,
  input  lwac_pkg::cfg_t                    cfg,
  output lwac_pkg::drive_t                  res
);

  localparam int PROD_W = lwac_pkg::MAG_W + 16;
  localparam int SCL_W  = PROD_W - 8;

  logic [lwac_pkg::MAG_W-1:0]  mag;
  logic [PROD_W-1:0]           prod;
  logic [SCL_W-1:0]            scaled;
  logic [SCL_W-1:0]            raised;
  logic [lwac_pkg::RATE_W-1:0] rate;
  logic                        positive;

  always_comb begin
    mag      = err[lwac_pkg::ERR_W-1] ? lwac_pkg::MAG_W'(-err)
                                      : err[lwac_pkg::MAG_W-1:0];
    positive = !err[lwac_pkg::ERR_W-1] && (err != '0);
    prod     = PROD_W'(mag) * PROD_W'(cfg.gain_q8);
    scaled   = prod[PROD_W-1:8];
    // raise to minimum outside the deadzone, then clamp; clamp wins
    if (scaled > SCL_W'(cfg.dead_rate) && scaled < SCL_W'(cfg.min_rate)) begin
      raised = SCL_W'(cfg.min_rate);
    end else begin
      raised = scaled;
    end
    if (raised > SCL_W'(cfg.max_rate)) begin
      rate = cfg.max_rate;
    end else begin
      rate = raised[lwac_pkg::RATE_W-1:0];
    end
    res.aligned = mag < lwac_pkg::MAG_W'(cfg.tolerance_mm);
    res.drive   = positive ? -$signed({1'b0, rate}) : $signed({1'b0, rate});
  end

endmodule

/* design/lidar_wall_align_controller.sv */
// Wall alignment regulator. Each input transaction gives exactly one result
// transaction. A start (command 0) latches side or end mode from direction and clears
// the timers; each tick (command 1) while running takes three ranges, forms the alignment
// error, a proportional drive (Q8.8 gain, minimum speed outside the deadzone, maximum
// clamp) and the status, and runs the settle and timeout checks. The item is held in an
// input register, all work including the 17x16 gain multiply is done in one pass, and
// the result lands in an output register, so throughput is one transaction per clock
// while result_stall is low. Registers are on the APB port at byte address 4*index and
// should only be written while idle.
module lidar_wall_align_controller (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               item_valid,
  output logic                               item_stall,
  input  logic                               command,
  input  logic [1:0]                         direction,
  input  logic [15:0]                        range_ahead,
  input  logic [15:0]                        range_behind,
  input  logic [15:0]                        range_center,
  output logic                               result_valid,
  input  logic                               result_stall,
  output logic signed [lwac_pkg::DRIVE_W-1:0] drive_rate,
  output logic signed [lwac_pkg::ERR_W-1:0]  align_error,
  output logic [15:0]                        elapsed,
  output logic [2:0]                         status,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [4:0]                         paddr,
  input  logic [31:0]                        pwdata,
  output logic [31:0]                        prdata,
  output logic                               pready
);

  lwac_pkg::cfg_t cfg;

  logic        hold_valid;
  logic        hold_command;
  logic [1:0]  hold_direction;
  logic [15:0] hold_plus;
  logic [15:0] hold_minus;
  logic [15:0] hold_center;
  logic        advance;

  logic                         running, running_next;
  logic                         verifying, verifying_next;
  logic [1:0]                   mode, mode_next;
  logic [lwac_pkg::CNT_W-1:0]   tick_count, tick_count_next;
  logic [lwac_pkg::CNT_W-1:0]   settle_start, settle_start_next;

  logic signed [lwac_pkg::ERR_W-1:0]   err;
  lwac_pkg::drive_t                    drv;
  logic signed [lwac_pkg::DRIVE_W-1:0] drive_next;
  logic signed [lwac_pkg::ERR_W-1:0]   error_next;
  logic [lwac_pkg::CNT_W-1:0]          elapsed_next;
  lwac_pkg::status_t                   status_next;

  // configuration port
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= lwac_pkg::CFG_RESET;
    end else if (psel && penable && pwrite && pready) begin
      case (paddr[4:2])
        lwac_pkg::REG_TOLERANCE: cfg.tolerance_mm  <= pwdata[15:0];
        lwac_pkg::REG_GAIN:      cfg.gain_q8       <= pwdata[15:0];
        lwac_pkg::REG_MIN_RATE:  cfg.min_rate      <= pwdata[11:0];
        lwac_pkg::REG_MAX_RATE:  cfg.max_rate      <= pwdata[11:0];
        lwac_pkg::REG_DEAD_RATE: cfg.dead_rate     <= pwdata[11:0];
        lwac_pkg::REG_VERIFY:    cfg.verify_ticks  <= pwdata[15:0];
        lwac_pkg::REG_TIMEOUT:   cfg.timeout_ticks <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:2])
      lwac_pkg::REG_TOLERANCE: prdata = {16'd0, cfg.tolerance_mm};
      lwac_pkg::REG_GAIN:      prdata = {16'd0, cfg.gain_q8};
      lwac_pkg::REG_MIN_RATE:  prdata = {20'd0, cfg.min_rate};
      lwac_pkg::REG_MAX_RATE:  prdata = {20'd0, cfg.max_rate};
      lwac_pkg::REG_DEAD_RATE: prdata = {20'd0, cfg.dead_rate};
      lwac_pkg::REG_VERIFY:    prdata = {16'd0, cfg.verify_ticks};
      lwac_pkg::REG_TIMEOUT:   prdata = {16'd0, cfg.timeout_ticks};
      default:                 prdata = 32'd0;
    endcase
  end

  // handshake
  assign advance    = hold_valid && (!result_valid || !result_stall);
  assign item_stall = hold_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (!item_stall) begin
      hold_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && !item_stall) begin
      hold_command   <= command;
      hold_direction <= direction;
      hold_plus      <= range_ahead;
      hold_minus     <= range_behind;
      hold_center    <= range_center;
    end
  end

  // error and drive
  always_comb begin
    if (mode inside {lwac_pkg::DIR_RIGHT, lwac_pkg::DIR_LEFT}) begin
      err = $signed({2'b00, hold_plus}) - $signed({2'b00, hold_minus});
    end else begin
      err = $signed({2'b00, hold_plus}) + $signed({2'b00, hold_minus})
          - $signed({1'b0, hold_center, 1'b0});
    end
  end

  lwac_drive u_drive (
    .err (err),
    .cfg (cfg),
    .res (drv)
  );

  always_comb begin
    running_next      = running;
    verifying_next    = verifying;
    mode_next         = mode;
    tick_count_next   = tick_count;
    settle_start_next = settle_start;
    drive_next        = '0;
    error_next        = '0;
    elapsed_next      = tick_count;
    status_next       = lwac_pkg::ST_IDLE;
    if (hold_command == lwac_pkg::CMD_START) begin
      mode_next         = hold_direction;
      running_next      = 1'b1;
      verifying_next    = 1'b0;
      tick_count_next   = '0;
      settle_start_next = '0;
      elapsed_next      = '0;
      status_next       = lwac_pkg::ST_ALIGNING;
    end else if (running) begin
      if (tick_count > cfg.timeout_ticks) begin
        running_next   = 1'b0;
        verifying_next = 1'b0;
        status_next    = lwac_pkg::ST_TIMED_OUT;
      end else begin
        if (tick_count != '1) begin
          tick_count_next = tick_count + 1'b1;
        end
        error_next = err;
        if (drv.aligned) begin
          status_next = lwac_pkg::ST_VERIFYING;
          if (!verifying) begin
            verifying_next    = 1'b1;
            settle_start_next = tick_count;
          end else if ((tick_count - settle_start) >= cfg.verify_ticks) begin
            running_next   = 1'b0;
            verifying_next = 1'b0;
            status_next    = lwac_pkg::ST_SUCCEEDED;
          end
        end else begin
          verifying_next = 1'b0;
          status_next    = lwac_pkg::ST_ALIGNING;
          drive_next     = drv.drive;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running      <= 1'b0;
      verifying    <= 1'b0;
      mode         <= lwac_pkg::DIR_RIGHT;
      tick_count   <= '0;
      settle_start <= '0;
      result_valid <= 1'b0;
    end else begin
      if (advance) begin
        running      <= running_next;
        verifying    <= verifying_next;
        mode         <= mode_next;
        tick_count   <= tick_count_next;
        settle_start <= settle_start_next;
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      drive_rate  <= drive_next;
      align_error <= error_next;
      elapsed     <= elapsed_next;
      status      <= status_next;
    end
  end

endmodule

/* design/lwac_checker.sv */
module lwac_checker (
  input logic                               clk,
  input logic                               rst,
  input logic                               result_valid,
  input logic                               result_stall,
  input logic signed [lwac_pkg::DRIVE_W-1:0] drive_rate,
  input logic signed [lwac_pkg::ERR_W-1:0]  align_error,
  input logic [15:0]                        elapsed,
  input logic [2:0]                         status
);

  // a stalled result transaction holds
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(drive_rate)
      && $stable(align_error) && $stable(elapsed) && $stable(status))
    else $error("result changed while stalled");

  // drive only while aligning
  a_drive_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && (status != 3'(lwac_pkg::ST_ALIGNING)) |-> drive_rate == '0)
    else $error("nonzero drive outside aligning");

  // no error reported when idle or timed out
  a_error_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && (status == 3'(lwac_pkg::ST_IDLE)
      || status == 3'(lwac_pkg::ST_TIMED_OUT)) |-> align_error == '0)
    else $error("error reported when idle or timed out");

  // drive opposes the error
  a_drive_sign: assert property (@(posedge clk) disable iff (rst)
    result_valid && (drive_rate != '0) |-> (drive_rate[lwac_pkg::DRIVE_W-1]
      != align_error[lwac_pkg::ERR_W-1]) && (align_error != '0))
    else $error("drive does not oppose error");

endmodule

bind lidar_wall_align_controller lwac_checker u_lwac_checker (.*);
